>>> hw/rtl/uart_buffered_fifo_pair_assert.svh
// assertion macros for the uart buffered fifo pair checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef UART_BUFFERED_FIFO_PAIR_ASSERT_SVH
`define UART_BUFFERED_FIFO_PAIR_ASSERT_SVH

// implication checked every clock, off while in reset
`define UBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same, with the consequent in the cycle after the antecedent
`define UBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  `UBF_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/ubf_pkg.sv
// shared types and constants of the uart buffered fifo pair
// no dependencies
package ubf_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FILL_W = 6;
  localparam logic [FILL_W-1:0] TX_LIMIT_RESET = 6'd60;

  typedef enum logic [1:0] {
    ACT_RX_BYTE   = 2'd0,
    ACT_HOST_PUT  = 2'd1,
    ACT_TX_DONE   = 2'd2,
    ACT_HOST_READ = 2'd3
  } ubf_action_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } ubf_state_e;

  // controller to datapath
  typedef struct packed {
    logic step;
  } ubf_cmd_t;

endpackage

>>> hw/rtl/ubf_evt_if.sv
// event channel: valid/ready handshake carrying one byte event
// depends on ubf_pkg
interface ubf_evt_if
  import ubf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

>>> hw/rtl/ubf_res_if.sv
// result channel: valid/ready handshake carrying one step result
// depends on ubf_pkg
interface ubf_res_if
  import ubf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              send_valid;
  logic [BYTE_W-1:0] send_byte;
  logic              read_valid;
  logic [BYTE_W-1:0] read_byte;
  logic              put_accepted;
  logic [FILL_W-1:0] rx_fill;
  logic [FILL_W-1:0] tx_fill;
  logic              idle_out;

  modport source (
    output valid, output send_valid, output send_byte, output read_valid,
    output read_byte, output put_accepted, output rx_fill, output tx_fill,
    output idle_out, input ready
  );
  modport sink (
    input valid, input send_valid, input send_byte, input read_valid,
    input read_byte, input put_accepted, input rx_fill, input tx_fill,
    input idle_out, output ready
  );
endinterface

>>> hw/rtl/uart_buffered_fifo_pair.sv
// Paired uart receive and transmit ring buffers with transmitter kick.
// evt_i takes one event per transfer: action 0 stores a line byte, 1 queues a
// host byte (refused while the transmit fill is above tx_fill_limit), 2 marks
// transmit complete, 3 reads the oldest received byte for the host.
// res_o returns exactly one result per event: the byte handed to the
// transmitter, the byte read, put status, both fills and the idle flag.
// Latency: the result is valid in the cycle after the event transfer.
// One event is held at a time, none is taken until the result is accepted;
// the stores read through a registered port on the transfer edge.
// A stalled result (res_o.ready low) stays stable and blocks evt_i.
// cfg_we_i writes tx_fill_limit from cfg_wdata_i; write it only while idle.
// Reset clears all pointers, sets the transmitter idle and the limit to 60;
// the byte stores are not cleared and need no clearing pass.
// There is no receive overflow check: the ring wraps silently.
module uart_buffered_fifo_pair
  import ubf_pkg::*;
#(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ubf_evt_if.sink           evt_i,
  ubf_res_if.source         res_o,
  input  logic              cfg_we_i,
  input  logic [FILL_W-1:0] cfg_wdata_i
);

  ubf_cmd_t cmd;

  ubf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (evt_i.valid),
    .out_ready_i (res_o.ready),
    .in_ready_o  (evt_i.ready),
    .out_valid_o (res_o.valid),
    .cmd_o       (cmd)
  );

  ubf_datapath #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (evt_i.action),
    .data_byte_i    (evt_i.data_byte),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .send_valid_o   (res_o.send_valid),
    .send_byte_o    (res_o.send_byte),
    .read_valid_o   (res_o.read_valid),
    .read_byte_o    (res_o.read_byte),
    .put_accepted_o (res_o.put_accepted),
    .rx_fill_o      (res_o.rx_fill),
    .tx_fill_o      (res_o.tx_fill),
    .idle_out_o     (res_o.idle_out)
  );

endmodule

>>> hw/rtl/ubf_ctrl.sv
// handshake controller of the uart buffered fifo pair
// depends on ubf_pkg; drives the datapath through ubf_cmd_t
module ubf_ctrl
  import ubf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_ready_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output ubf_cmd_t cmd_o
);

  ubf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.step = in_valid_i;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/ubf_datapath.sv
// ring pointers, byte stores and result registers of the fifo pair
// depends on ubf_pkg; stepped by ubf_ctrl through ubf_cmd_t
module ubf_datapath
  import ubf_pkg::*;
#(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ubf_cmd_t          cmd_i,
  input  logic [1:0]        action_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              cfg_we_i,
  input  logic [FILL_W-1:0] cfg_wdata_i,
  output logic              send_valid_o,
  output logic [BYTE_W-1:0] send_byte_o,
  output logic              read_valid_o,
  output logic [BYTE_W-1:0] read_byte_o,
  output logic              put_accepted_o,
  output logic [FILL_W-1:0] rx_fill_o,
  output logic [FILL_W-1:0] tx_fill_o,
  output logic              idle_out_o
);

  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW = $clog2(TX_DEPTH);
  localparam int unsigned RX_PW = RX_AW + 1;
  localparam int unsigned TX_PW = TX_AW + 1;
  localparam int unsigned RX_FW = (RX_AW > FILL_W) ? RX_AW : FILL_W;
  localparam int unsigned TX_FW = (TX_AW > FILL_W) ? TX_AW : FILL_W;

  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

  logic [RX_AW-1:0]  rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d;
  logic [TX_AW-1:0]  tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d;
  logic              idle_q, idle_d;
  logic [FILL_W-1:0] limit_q;

  logic              send_v_q, send_v_d;
  logic              bypass_q, bypass_d;
  logic              read_v_q, read_v_d;
  logic              put_q, put_d;
  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] rx_rd_q, tx_rd_q;

  logic [RX_PW-1:0]  rx_diff;
  logic [TX_PW-1:0]  tx_diff;
  logic [RX_AW-1:0]  rx_fill;
  logic [TX_AW-1:0]  tx_fill;
  logic [RX_FW-1:0]  rx_fill_ext;
  logic [TX_FW-1:0]  tx_fill_ext;
  logic [RX_AW-1:0]  rx_wp_inc, rx_rp_inc;
  logic [TX_AW-1:0]  tx_wp_inc, tx_rp_inc;
  logic              put_ok, rx_we, tx_we;
  ubf_action_e       act;

  // fill is (write - read) modulo the depth
  assign rx_diff = {1'b0, rx_wp_q} - {1'b0, rx_rp_q}
                 + ((rx_wp_q < rx_rp_q) ? RX_PW'(RX_DEPTH) : '0);
  assign tx_diff = {1'b0, tx_wp_q} - {1'b0, tx_rp_q}
                 + ((tx_wp_q < tx_rp_q) ? TX_PW'(TX_DEPTH) : '0);
  assign rx_fill = rx_diff[RX_AW-1:0];
  assign tx_fill = tx_diff[TX_AW-1:0];
  assign rx_fill_ext = RX_FW'(rx_fill);
  assign tx_fill_ext = TX_FW'(tx_fill);

  assign rx_wp_inc = (rx_wp_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wp_q + 1'b1;
  assign rx_rp_inc = (rx_rp_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rp_q + 1'b1;
  assign tx_wp_inc = (tx_wp_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wp_q + 1'b1;
  assign tx_rp_inc = (tx_rp_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rp_q + 1'b1;

  assign act    = ubf_action_e'(action_i);
  assign put_ok = (act == ACT_HOST_PUT) && (tx_fill_ext <= TX_FW'(limit_q));
  assign rx_we  = cmd_i.step && (act == ACT_RX_BYTE);
  assign tx_we  = cmd_i.step && put_ok;

  always_comb begin
    rx_wp_d  = rx_wp_q;
    rx_rp_d  = rx_rp_q;
    tx_wp_d  = tx_wp_q;
    tx_rp_d  = tx_rp_q;
    idle_d   = idle_q;
    send_v_d = 1'b0;
    bypass_d = 1'b0;
    read_v_d = 1'b0;
    put_d    = 1'b0;
    unique case (act)
      ACT_RX_BYTE: begin
        rx_wp_d = rx_wp_inc;
      end
      ACT_HOST_PUT: begin
        if (put_ok) begin
          tx_wp_d = tx_wp_inc;
          put_d   = 1'b1;
          // idle means the ring was empty: the new byte goes straight out
          if (idle_q) begin
            tx_rp_d  = tx_rp_inc;
            idle_d   = 1'b0;
            send_v_d = 1'b1;
            bypass_d = 1'b1;
          end
        end
      end
      ACT_TX_DONE: begin
        idle_d = (tx_rp_q == tx_wp_q);
        if (tx_rp_q != tx_wp_q) begin
          tx_rp_d  = tx_rp_inc;
          send_v_d = 1'b1;
        end
      end
      ACT_HOST_READ: begin
        if (rx_rp_q != rx_wp_q) begin
          rx_rp_d  = rx_rp_inc;
          read_v_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wp_q  <= '0;
      rx_rp_q  <= '0;
      tx_wp_q  <= '0;
      tx_rp_q  <= '0;
      idle_q   <= 1'b1;
      limit_q  <= TX_LIMIT_RESET;
      send_v_q <= 1'b0;
      bypass_q <= 1'b0;
      read_v_q <= 1'b0;
      put_q    <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (cmd_i.step) begin
        rx_wp_q  <= rx_wp_d;
        rx_rp_q  <= rx_rp_d;
        tx_wp_q  <= tx_wp_d;
        tx_rp_q  <= tx_rp_d;
        idle_q   <= idle_d;
        send_v_q <= send_v_d;
        bypass_q <= bypass_d;
        read_v_q <= read_v_d;
        put_q    <= put_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) byte_q <= data_byte_i;
  end

  // stores read at the old read pointer on each transfer in
  always_ff @(posedge clk_i) begin
    if (rx_we) rx_mem[rx_wp_q] <= data_byte_i;
    if (cmd_i.step) rx_rd_q <= rx_mem[rx_rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) tx_mem[tx_wp_q] <= data_byte_i;
    if (cmd_i.step) tx_rd_q <= tx_mem[tx_rp_q];
  end

  // result registers only change on step, so the result holds while stalled
  assign send_valid_o   = send_v_q;
  assign send_byte_o    = !send_v_q ? '0 : (bypass_q ? byte_q : tx_rd_q);
  assign read_valid_o   = read_v_q;
  assign read_byte_o    = read_v_q ? rx_rd_q : '0;
  assign put_accepted_o = put_q;
  assign rx_fill_o      = rx_fill_ext[FILL_W-1:0];
  assign tx_fill_o      = tx_fill_ext[FILL_W-1:0];
  assign idle_out_o     = idle_q;

endmodule

>>> hw/rtl/ubf_checker.sv
// port-level checker for uart_buffered_fifo_pair, attached by bind
// depends on ubf_pkg and uart_buffered_fifo_pair_assert.svh
`include "uart_buffered_fifo_pair_assert.svh"

module ubf_checker
  import ubf_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              send_valid_i,
  input logic [BYTE_W-1:0] send_byte_i,
  input logic              read_valid_i,
  input logic              put_accepted_i
);

  logic shape_ok;

  // a read result never comes with a put or a send, idle send byte is zero
  assign shape_ok = !(read_valid_i && (send_valid_i || put_accepted_i))
                  && (send_valid_i || (send_byte_i == '0));

  // a stalled result stays offered
  `UBF_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")

  // every event transfer yields a result in the next cycle
  `UBF_ASSERT_NEXT(a_out_after_in, in_valid_i && in_ready_i, out_valid_i, "result missing")

  // one event at a time: no new transfer while a result is pending
  `UBF_ASSERT(a_one_in_flight, out_valid_i |-> !in_ready_i, "input open while busy")

  `UBF_ASSERT(a_result_shape, out_valid_i |-> shape_ok, "bad result mix")

endmodule

bind uart_buffered_fifo_pair ubf_checker u_ubf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (evt_i.valid),
  .in_ready_i     (evt_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .send_valid_i   (res_o.send_valid),
  .send_byte_i    (res_o.send_byte),
  .read_valid_i   (res_o.read_valid),
  .put_accepted_i (res_o.put_accepted)
);
